[sv/rmbp_pkg.sv]
// Shared types and constants of the multibulk request parser.
`default_nettype none

package rmbp_pkg;

    localparam int MAX_LINE_BYTES_DEFAULT = 32;

    localparam int COUNT_W = 21;
    localparam int LEN_W   = 30;
    localparam int ACC_W   = 31;

    localparam logic [COUNT_W-1:0] MAX_ARG_COUNT_RESET   = 21'd1048576;
    localparam logic [LEN_W-1:0]   MAX_BULK_LENGTH_RESET = 30'd536870912;

    // accumulator saturates above any accepted value
    localparam logic [ACC_W-1:0] ACC_SAT       = 31'd1073741824;
    localparam logic [ACC_W-1:0] ACC_SAT_DIV10 = 31'd107374182;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // configuration register indexes
    localparam logic CFG_MAX_ARG_COUNT   = 1'b0;
    localparam logic CFG_MAX_BULK_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_COUNT_LINE = 4'd1,
        PH_COUNT_LF   = 4'd2,
        PH_LEN_START  = 4'd3,
        PH_LEN_LINE   = 4'd4,
        PH_LEN_LF     = 4'd5,
        PH_DATA       = 4'd6,
        PH_TRAIL1     = 4'd7,
        PH_TRAIL2     = 4'd8,
        PH_ERROR      = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_COUNT   = 3'd0,
        KIND_EMPTY   = 3'd1,
        KIND_ARG     = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_ARG_END = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    localparam logic [LEN_W-1:0] ERR_INLINE     = 30'd1;
    localparam logic [LEN_W-1:0] ERR_BAD_COUNT  = 30'd2;
    localparam logic [LEN_W-1:0] ERR_NO_DOLLAR  = 30'd3;
    localparam logic [LEN_W-1:0] ERR_BAD_LENGTH = 30'd4;
    localparam logic [LEN_W-1:0] ERR_LONG_LINE  = 30'd5;

    typedef struct packed {
        logic zero;
        logic bad;
        logic digit;
        logic neg;
    } num_flags_t;

    typedef struct packed {
        kind_t            kind;
        logic [LEN_W-1:0] value;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

[sv/rmbp_number.sv]
// Decimal header-line digit step: sign, leading-zero rules, saturating accumulate and line-length count.
`default_nettype none

module rmbp_number #(
    parameter int MAX_LINE_BYTES = rmbp_pkg::MAX_LINE_BYTES_DEFAULT,
    parameter int LINE_W         = $clog2(MAX_LINE_BYTES + 1)
) (
    input  wire logic [7:0]                   data_byte,
    input  wire logic [rmbp_pkg::ACC_W-1:0]   acc_in,
    input  wire rmbp_pkg::num_flags_t         flags_in,
    input  wire logic [LINE_W-1:0]            len_in,
    output logic      [rmbp_pkg::ACC_W-1:0]   acc_out,
    output rmbp_pkg::num_flags_t              flags_out,
    output logic      [LINE_W-1:0]            len_out,
    output logic                              overlong
);

    localparam logic [LINE_W-1:0] MAX_LEN = LINE_W'(MAX_LINE_BYTES);

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [rmbp_pkg::ACC_W+3:0]    acc_x10;

    assign is_digit = (data_byte >= rmbp_pkg::CHAR_ZERO) && (data_byte <= rmbp_pkg::CHAR_NINE);
    assign digit    = 4'(data_byte - rmbp_pkg::CHAR_ZERO);
    // acc * 10 + d as two shifts and two adds
    assign acc_x10  = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                      + (rmbp_pkg::ACC_W+4)'(digit);
    assign overlong = (len_in >= MAX_LEN);

    always_comb
    begin
        acc_out   = acc_in;
        flags_out = flags_in;
        len_out   = len_in;
        if (!overlong)
        begin
            len_out = len_in + LINE_W'(1);
            if (!flags_in.bad)
            begin
                if ((data_byte == rmbp_pkg::CHAR_MINUS) && (flags_in == '0))
                begin
                    flags_out.neg = 1'b1;
                end
                else if (is_digit)
                begin
                    if (!flags_in.digit)
                    begin
                        if (digit == 4'd0)
                        begin
                            if (flags_in.neg)
                                flags_out.bad = 1'b1;
                            else
                                flags_out.zero = 1'b1;
                        end
                        flags_out.digit = 1'b1;
                        acc_out = rmbp_pkg::ACC_W'(digit);
                    end
                    else if (flags_in.zero)
                    begin
                        flags_out.bad = 1'b1;
                    end
                    else if ((acc_in >= rmbp_pkg::ACC_SAT_DIV10)
                             || (acc_x10 > (rmbp_pkg::ACC_W+4)'(rmbp_pkg::ACC_SAT)))
                    begin
                        acc_out = rmbp_pkg::ACC_SAT;
                    end
                    else
                    begin
                        acc_out = acc_x10[rmbp_pkg::ACC_W-1:0];
                    end
                end
                else
                begin
                    flags_out.bad = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/rmbp_core.sv]
// Parser state machine, counters and configuration registers.
`default_nettype none

module rmbp_core #(
    parameter int MAX_LINE_BYTES = rmbp_pkg::MAX_LINE_BYTES_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [rmbp_pkg::LEN_W-1:0]   cfg_data,
    input  wire logic                         step,
    input  wire logic [7:0]                   data_byte,
    output logic                              res_valid,
    output rmbp_pkg::result_t                 res
);

    localparam int LINE_W = $clog2(MAX_LINE_BYTES + 1);

    rmbp_pkg::phase_t                phase_reg, phase_next;
    logic [rmbp_pkg::COUNT_W-1:0]    args_left_reg, args_left_next;
    logic [rmbp_pkg::LEN_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [rmbp_pkg::ACC_W-1:0]      acc_reg, acc_next;
    rmbp_pkg::num_flags_t            flags_reg, flags_next;
    logic [LINE_W-1:0]               line_len_reg, line_len_next;
    logic [rmbp_pkg::COUNT_W-1:0]    max_arg_count_reg;
    logic [rmbp_pkg::LEN_W-1:0]      max_bulk_length_reg;

    logic [rmbp_pkg::ACC_W-1:0]      num_acc;
    rmbp_pkg::num_flags_t            num_flags;
    logic [LINE_W-1:0]               num_len;
    logic                            overlong;

    logic                            number_ok;
    logic                            count_empty;
    logic                            count_big;
    logic                            len_bad;
    logic [rmbp_pkg::COUNT_W-1:0]    args_dec;
    logic [rmbp_pkg::LEN_W-1:0]      bytes_dec;

    rmbp_number #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .LINE_W         (LINE_W)
    ) u_number (
        .data_byte (data_byte),
        .acc_in    (acc_reg),
        .flags_in  (flags_reg),
        .len_in    (line_len_reg),
        .acc_out   (num_acc),
        .flags_out (num_flags),
        .len_out   (num_len),
        .overlong  (overlong)
    );

    assign number_ok   = flags_reg.digit && !flags_reg.bad;
    assign count_empty = flags_reg.neg || (acc_reg == '0);
    assign count_big   = acc_reg > rmbp_pkg::ACC_W'(max_arg_count_reg);
    assign len_bad     = !number_ok || flags_reg.neg
                         || (acc_reg > rmbp_pkg::ACC_W'(max_bulk_length_reg));
    assign args_dec    = args_left_reg - rmbp_pkg::COUNT_W'(1);
    assign bytes_dec   = bytes_left_reg - rmbp_pkg::LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_arg_count_reg   <= rmbp_pkg::MAX_ARG_COUNT_RESET;
            max_bulk_length_reg <= rmbp_pkg::MAX_BULK_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rmbp_pkg::CFG_MAX_ARG_COUNT:
                    max_arg_count_reg <= cfg_data[rmbp_pkg::COUNT_W-1:0];
                rmbp_pkg::CFG_MAX_BULK_LENGTH:
                    max_bulk_length_reg <= cfg_data;
                default:
                    max_arg_count_reg <= max_arg_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rmbp_pkg::PH_IDLE;
            args_left_reg  <= '0;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            flags_reg      <= '0;
            line_len_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            args_left_reg  <= args_left_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            flags_reg      <= flags_next;
            line_len_reg   <= line_len_next;
        end
    end

    // next state and counters
    always_comb
    begin
        phase_next      = phase_reg;
        args_left_next  = args_left_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        flags_next      = flags_reg;
        line_len_next   = line_len_reg;
        if (step)
        begin
            case (phase_reg)
                rmbp_pkg::PH_IDLE:
                begin
                    if (data_byte != rmbp_pkg::CHAR_STAR)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else
                    begin
                        acc_next      = '0;
                        flags_next    = '0;
                        line_len_next = LINE_W'(1);
                        phase_next    = rmbp_pkg::PH_COUNT_LINE;
                    end
                end
                rmbp_pkg::PH_COUNT_LINE, rmbp_pkg::PH_LEN_LINE:
                begin
                    if (data_byte == rmbp_pkg::CHAR_CR)
                        phase_next = (phase_reg == rmbp_pkg::PH_COUNT_LINE)
                                     ? rmbp_pkg::PH_COUNT_LF : rmbp_pkg::PH_LEN_LF;
                    else if (overlong)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else
                    begin
                        acc_next      = num_acc;
                        flags_next    = num_flags;
                        line_len_next = num_len;
                    end
                end
                rmbp_pkg::PH_COUNT_LF:
                begin
                    if (!number_ok)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else if (count_empty)
                        phase_next = rmbp_pkg::PH_IDLE;
                    else if (count_big)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else
                    begin
                        args_left_next = acc_reg[rmbp_pkg::COUNT_W-1:0];
                        phase_next     = rmbp_pkg::PH_LEN_START;
                    end
                end
                rmbp_pkg::PH_LEN_START:
                begin
                    if (data_byte != rmbp_pkg::CHAR_DOLLAR)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else
                    begin
                        acc_next      = '0;
                        flags_next    = '0;
                        line_len_next = LINE_W'(1);
                        phase_next    = rmbp_pkg::PH_LEN_LINE;
                    end
                end
                rmbp_pkg::PH_LEN_LF:
                begin
                    if (len_bad)
                        phase_next = rmbp_pkg::PH_ERROR;
                    else
                    begin
                        bytes_left_next = acc_reg[rmbp_pkg::LEN_W-1:0];
                        phase_next      = (acc_reg != '0) ? rmbp_pkg::PH_DATA
                                                          : rmbp_pkg::PH_TRAIL1;
                    end
                end
                rmbp_pkg::PH_DATA:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                        phase_next = rmbp_pkg::PH_TRAIL1;
                end
                rmbp_pkg::PH_TRAIL1:
                    phase_next = rmbp_pkg::PH_TRAIL2;
                rmbp_pkg::PH_TRAIL2:
                begin
                    args_left_next = args_dec;
                    phase_next     = (args_dec != '0) ? rmbp_pkg::PH_LEN_START
                                                      : rmbp_pkg::PH_IDLE;
                end
                default:
                    phase_next = rmbp_pkg::PH_ERROR;
            endcase
        end
    end

    // result word for this byte
    always_comb
    begin
        res_valid = 1'b0;
        res.kind  = rmbp_pkg::KIND_ERROR;
        res.value = '0;
        res.last  = 1'b0;
        if (step)
        begin
            case (phase_reg)
                rmbp_pkg::PH_IDLE:
                begin
                    if (data_byte != rmbp_pkg::CHAR_STAR)
                    begin
                        res_valid = 1'b1;
                        res.value = rmbp_pkg::ERR_INLINE;
                    end
                end
                rmbp_pkg::PH_COUNT_LINE, rmbp_pkg::PH_LEN_LINE:
                begin
                    if ((data_byte != rmbp_pkg::CHAR_CR) && overlong)
                    begin
                        res_valid = 1'b1;
                        res.value = rmbp_pkg::ERR_LONG_LINE;
                    end
                end
                rmbp_pkg::PH_COUNT_LF:
                begin
                    res_valid = 1'b1;
                    if (!number_ok)
                        res.value = rmbp_pkg::ERR_BAD_COUNT;
                    else if (count_empty)
                        res.kind = rmbp_pkg::KIND_EMPTY;
                    else if (count_big)
                        res.value = rmbp_pkg::ERR_BAD_COUNT;
                    else
                    begin
                        res.kind  = rmbp_pkg::KIND_COUNT;
                        res.value = rmbp_pkg::LEN_W'(acc_reg[rmbp_pkg::COUNT_W-1:0]);
                    end
                end
                rmbp_pkg::PH_LEN_START:
                begin
                    if (data_byte != rmbp_pkg::CHAR_DOLLAR)
                    begin
                        res_valid = 1'b1;
                        res.value = rmbp_pkg::ERR_NO_DOLLAR;
                    end
                end
                rmbp_pkg::PH_LEN_LF:
                begin
                    res_valid = 1'b1;
                    if (len_bad)
                        res.value = rmbp_pkg::ERR_BAD_LENGTH;
                    else
                    begin
                        res.kind  = rmbp_pkg::KIND_ARG;
                        res.value = acc_reg[rmbp_pkg::LEN_W-1:0];
                    end
                end
                rmbp_pkg::PH_DATA:
                begin
                    res_valid = 1'b1;
                    res.kind  = rmbp_pkg::KIND_DATA;
                    res.value = rmbp_pkg::LEN_W'(data_byte);
                end
                rmbp_pkg::PH_TRAIL2:
                begin
                    res_valid = 1'b1;
                    res.kind  = rmbp_pkg::KIND_ARG_END;
                    res.last  = (args_dec == '0);
                end
                default:
                    res_valid = 1'b0;
            endcase
        end
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rmbp_pkg::PH_ERROR |=> phase_reg == rmbp_pkg::PH_ERROR)
        else $error("parser left the error phase");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rmbp_pkg::PH_ERROR |-> !res_valid)
        else $error("result produced after an error");

    a_error_enters_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == rmbp_pkg::KIND_ERROR |=> phase_reg == rmbp_pkg::PH_ERROR)
        else $error("error word without entering the error phase");

endmodule

`default_nettype wire

[sv/rmbp_outq.sv]
// Output register with one skid entry; the input side waits only when both are occupied.
`default_nettype none

module rmbp_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire rmbp_pkg::result_t   push_data,
    output logic                     full,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output rmbp_pkg::result_t        out_data
);

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    rmbp_pkg::result_t    out_reg, out_next;
    rmbp_pkg::result_t    skid_reg, skid_next;
    logic                 pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("word pushed into a full output queue");

endmodule

`default_nettype wire

[sv/resp_multibulk_request_parser.sv]
// Multibulk request parser: byte stream in, request event words out.
//
// Input channel: one request byte per word (data_byte), in_valid/in_stall.
// Output channel: one event word (kind, value, last), out_valid/out_stall.
// kind: count header, empty request, argument start, data byte, argument
// end (last marks the request's final argument) or error with its code.
// After an error the block stays silent until reset.
// Takes one byte per cycle while in_stall is low. A byte's event word is formed
// from the parser state and the byte and registered in the output register.
// in_stall comes straight from a registered skid flag: the block keeps taking
// bytes while one finished word waits, and stalls only when both the output
// register and the skid entry are occupied.
// Configuration (cfg_write/cfg_index/cfg_data) sets max_arg_count (index 0)
// and max_bulk_length (index 1); write only while the block is idle.
// Reset (rst_n low, asynchronous) returns the parser to waiting for '*',
// empties the output and restores both limits to their defaults.
`default_nettype none

module resp_multibulk_request_parser #(
    parameter int MAX_LINE_BYTES = rmbp_pkg::MAX_LINE_BYTES_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [rmbp_pkg::LEN_W-1:0]   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   data_byte,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [2:0]                   kind,
    output logic      [rmbp_pkg::LEN_W-1:0]   value,
    output logic                              last
);

    logic                 step;
    logic                 res_valid;
    rmbp_pkg::result_t    res;
    rmbp_pkg::result_t    out_data;
    logic                 full;

    assign in_stall = full;
    assign step     = in_valid && !full;

    rmbp_core #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    rmbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind  = out_data.kind;
    assign value = out_data.value;
    assign last  = out_data.last;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the multibulk request parser: random request streams, checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX    = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // Predicts the event words of the parser and checks the words that come out.
    class request_checker #(int LINE_LIMIT = 32);
        rmbp_pkg::phase_t                 phase;
        logic [rmbp_pkg::COUNT_W-1:0]     args_left;
        logic [rmbp_pkg::LEN_W-1:0]       bytes_left;
        int unsigned                      accum;
        rmbp_pkg::num_flags_t             flags;
        int unsigned                      line_len;
        logic [rmbp_pkg::COUNT_W-1:0]     arg_limit;
        logic [rmbp_pkg::LEN_W-1:0]       len_limit;
        rmbp_pkg::result_t                expected_words[$];
        int                               errors;

        function new();
            phase      = rmbp_pkg::PH_IDLE;
            args_left  = '0;
            bytes_left = '0;
            accum      = 0;
            flags      = '0;
            line_len   = 0;
            arg_limit  = rmbp_pkg::MAX_ARG_COUNT_RESET;
            len_limit  = rmbp_pkg::MAX_BULK_LENGTH_RESET;
            errors     = 0;
        endfunction

        function void set_limit(logic idx, logic [rmbp_pkg::LEN_W-1:0] val);
            if (idx == rmbp_pkg::CFG_MAX_ARG_COUNT)
                arg_limit = val[rmbp_pkg::COUNT_W-1:0];
            else
                len_limit = val;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push(rmbp_pkg::kind_t k, logic [rmbp_pkg::LEN_W-1:0] v, logic l);
            rmbp_pkg::result_t r;
            r.kind  = k;
            r.value = v;
            r.last  = l;
            expected_words.push_back(r);
        endfunction

        function void raise_error(logic [rmbp_pkg::LEN_W-1:0] code);
            phase = rmbp_pkg::PH_ERROR;
            push(rmbp_pkg::KIND_ERROR, code, 1'b0);
        endfunction

        function void begin_line();
            accum    = 0;
            flags    = '0;
            line_len = 1;
        endfunction

        // one byte of a header number; returns 0 once the line is too long
        function bit take_line_byte(logic [7:0] b);
            int unsigned d;
            int unsigned nxt;
            if (line_len >= LINE_LIMIT)
                return 1'b0;
            line_len++;
            if (flags.bad)
                return 1'b1;
            if (b == rmbp_pkg::CHAR_MINUS && flags == '0)
            begin
                flags.neg = 1'b1;
            end
            else if (b >= rmbp_pkg::CHAR_ZERO && b <= rmbp_pkg::CHAR_NINE)
            begin
                d = 32'(b) - 32'(rmbp_pkg::CHAR_ZERO);
                if (!flags.digit)
                begin
                    if (d == 0)
                    begin
                        if (flags.neg)
                            flags.bad = 1'b1;
                        else
                            flags.zero = 1'b1;
                    end
                    flags.digit = 1'b1;
                    accum = d;
                end
                else if (flags.zero)
                begin
                    flags.bad = 1'b1;
                end
                else
                begin
                    nxt = accum * 10 + d;
                    // saturate above any limit that can be configured
                    if (accum >= 32'(rmbp_pkg::ACC_SAT_DIV10) || nxt > 32'(rmbp_pkg::ACC_SAT))
                        accum = 32'(rmbp_pkg::ACC_SAT);
                    else
                        accum = nxt;
                end
            end
            else
            begin
                flags.bad = 1'b1;
            end
            return 1'b1;
        endfunction

        function bit number_good();
            return flags.digit && !flags.bad;
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                rmbp_pkg::PH_IDLE:
                begin
                    if (b != rmbp_pkg::CHAR_STAR)
                    begin
                        raise_error(rmbp_pkg::ERR_INLINE);
                    end
                    else
                    begin
                        begin_line();
                        phase = rmbp_pkg::PH_COUNT_LINE;
                    end
                end
                rmbp_pkg::PH_COUNT_LINE, rmbp_pkg::PH_LEN_LINE:
                begin
                    if (b == rmbp_pkg::CHAR_CR)
                    begin
                        if (phase == rmbp_pkg::PH_COUNT_LINE)
                            phase = rmbp_pkg::PH_COUNT_LF;
                        else
                            phase = rmbp_pkg::PH_LEN_LF;
                    end
                    else if (!take_line_byte(b))
                    begin
                        raise_error(rmbp_pkg::ERR_LONG_LINE);
                    end
                end
                rmbp_pkg::PH_COUNT_LF:
                begin
                    if (!number_good())
                    begin
                        raise_error(rmbp_pkg::ERR_BAD_COUNT);
                    end
                    else if (flags.neg || accum == 0)
                    begin
                        phase = rmbp_pkg::PH_IDLE;
                        push(rmbp_pkg::KIND_EMPTY, '0, 1'b0);
                    end
                    else if (accum > 32'(arg_limit))
                    begin
                        raise_error(rmbp_pkg::ERR_BAD_COUNT);
                    end
                    else
                    begin
                        args_left = accum[rmbp_pkg::COUNT_W-1:0];
                        phase = rmbp_pkg::PH_LEN_START;
                        push(rmbp_pkg::KIND_COUNT, rmbp_pkg::LEN_W'(args_left), 1'b0);
                    end
                end
                rmbp_pkg::PH_LEN_START:
                begin
                    if (b != rmbp_pkg::CHAR_DOLLAR)
                    begin
                        raise_error(rmbp_pkg::ERR_NO_DOLLAR);
                    end
                    else
                    begin
                        begin_line();
                        phase = rmbp_pkg::PH_LEN_LINE;
                    end
                end
                rmbp_pkg::PH_LEN_LF:
                begin
                    if (!number_good() || flags.neg || accum > 32'(len_limit))
                    begin
                        raise_error(rmbp_pkg::ERR_BAD_LENGTH);
                    end
                    else
                    begin
                        bytes_left = accum[rmbp_pkg::LEN_W-1:0];
                        if (bytes_left != '0)
                            phase = rmbp_pkg::PH_DATA;
                        else
                            phase = rmbp_pkg::PH_TRAIL1;
                        push(rmbp_pkg::KIND_ARG, bytes_left, 1'b0);
                    end
                end
                rmbp_pkg::PH_DATA:
                begin
                    bytes_left--;
                    if (bytes_left == '0)
                        phase = rmbp_pkg::PH_TRAIL1;
                    push(rmbp_pkg::KIND_DATA, {22'd0, b}, 1'b0);
                end
                rmbp_pkg::PH_TRAIL1:
                begin
                    phase = rmbp_pkg::PH_TRAIL2;
                end
                rmbp_pkg::PH_TRAIL2:
                begin
                    args_left--;
                    if (args_left != '0)
                        phase = rmbp_pkg::PH_LEN_START;
                    else
                        phase = rmbp_pkg::PH_IDLE;
                    push(rmbp_pkg::KIND_ARG_END, '0, args_left == '0);
                end
                default:
                begin
                    phase = rmbp_pkg::PH_ERROR;
                end
            endcase
        endfunction

        function void check_word(logic [2:0] k, logic [rmbp_pkg::LEN_W-1:0] v, logic l);
            rmbp_pkg::result_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: kind %0d value %0d last %0d", k, v, l);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, k);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("value: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, l);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_words.size() != 0)
            begin
                $error("%0d expected words never arrived", expected_words.size());
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic                           cfg_index;
    logic [rmbp_pkg::LEN_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     data_byte;
    logic                           out_valid;
    logic                           out_stall;
    logic [2:0]                     kind;
    logic [rmbp_pkg::LEN_W-1:0]     value;
    logic                           last;

    request_checker #(LINE_MAX) board;
    int in_mode;
    int out_mode;
    int items_sent;
    int cycles;
    int stall_left;

    resp_multibulk_request_parser #(
        .MAX_LINE_BYTES(LINE_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .value(value),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mode 0: never idle; 1: light; 2: heavy
    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(4, 20);
        end
        if (r < 30)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(5, 30);
    endfunction

    // output side: check accepted words, then decide the stall for the next cycle
    initial
    begin
        out_stall <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                board.check_word(kind, value, last);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(out_mode);
            out_stall <= (stall_left > 0);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(in_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_byte(b);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // marker, number text, CR, then the unchecked line-feed position
    task automatic send_line(input logic [7:0] marker, input string num);
        send_byte(marker);
        send_text(num);
        send_byte(rmbp_pkg::CHAR_CR);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_argument(input int len);
        send_line(rmbp_pkg::CHAR_DOLLAR, $sformatf("%0d", len));
        repeat (len)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_len();
        int cap;
        int hi;
        int r;
        cap = (board.len_limit < 64) ? int'(board.len_limit) : 64;
        r = $urandom_range(0, 99);
        if (r < 70)
            hi = 6;
        else if (r < 95)
            hi = 20;
        else
            hi = 64;
        if (hi > cap)
            hi = cap;
        return $urandom_range(0, hi);
    endfunction

    // zero, small negative, or a long negative that may saturate (up to a full-length line)
    task automatic send_empty_request();
        int n;
        case ($urandom_range(0, 2))
            0: send_line(rmbp_pkg::CHAR_STAR, "0");
            1: send_line(rmbp_pkg::CHAR_STAR, $sformatf("-%0d", $urandom_range(1, 100000)));
            default:
            begin
                send_byte(rmbp_pkg::CHAR_STAR);
                send_byte(rmbp_pkg::CHAR_MINUS);
                send_byte(rmbp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
                n = $urandom_range(0, 1) ? LINE_MAX - 3 : $urandom_range(8, LINE_MAX - 3);
                repeat (n)
                    send_byte(rmbp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                send_byte(rmbp_pkg::CHAR_CR);
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_random_request();
        int r;
        int nargs;
        int cap;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            send_empty_request();
        end
        else
        begin
            cap = (board.arg_limit < 8) ? int'(board.arg_limit) : 8;
            if (r < 20)
                nargs = cap;
            else
                nargs = $urandom_range(1, (cap < 4) ? cap : 4);
            send_line(rmbp_pkg::CHAR_STAR, $sformatf("%0d", nargs));
            repeat (nargs)
                send_argument(pick_len());
        end
    endtask

    task automatic send_bad_number(input logic [7:0] marker, input bit neg_ok);
        logic [7:0] junk;
        send_byte(marker);
        case ($urandom_range(0, neg_ok ? 5 : 4))
            0: ;
            1: send_byte(rmbp_pkg::CHAR_MINUS);
            2: send_text("-0");
            3: send_text("01");
            4:
            begin
                do
                    junk = 8'($urandom_range(0, 255));
                while ((junk >= rmbp_pkg::CHAR_ZERO && junk <= rmbp_pkg::CHAR_NINE)
                       || junk == rmbp_pkg::CHAR_CR);
                send_byte(rmbp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
                send_byte(junk);
            end
            default: send_text($sformatf("-%0d", $urandom_range(1, 999)));
        endcase
        send_byte(rmbp_pkg::CHAR_CR);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    // an error is terminal, so exactly one broken request ends the stream
    task automatic send_broken_request();
        logic [7:0] b;
        int sub;
        case ($urandom_range(0, 4))
            0:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == rmbp_pkg::CHAR_STAR);
                send_byte(b);
            end
            1:
            begin
                sub = $urandom_range(0, 2);
                if (sub == 0)
                    send_bad_number(rmbp_pkg::CHAR_STAR, 1'b0);
                else if (sub == 1)
                    send_line(rmbp_pkg::CHAR_STAR, $sformatf("%0d", board.arg_limit + 1));
                else
                    send_line(rmbp_pkg::CHAR_STAR, "98765432109");
            end
            2:
            begin
                send_line(rmbp_pkg::CHAR_STAR, "1");
                do
                    b = 8'($urandom_range(0, 255));
                while (b == rmbp_pkg::CHAR_DOLLAR);
                send_byte(b);
            end
            3:
            begin
                send_line(rmbp_pkg::CHAR_STAR, "2");
                send_argument(pick_len());
                sub = $urandom_range(0, 2);
                if (sub == 0)
                    send_bad_number(rmbp_pkg::CHAR_DOLLAR, 1'b1);
                else if (sub == 1)
                    send_line(rmbp_pkg::CHAR_DOLLAR, $sformatf("%0d", board.len_limit + 1));
                else
                    send_line(rmbp_pkg::CHAR_DOLLAR, "1073741825");
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    send_byte(rmbp_pkg::CHAR_STAR);
                end
                else
                begin
                    send_line(rmbp_pkg::CHAR_STAR, "1");
                    send_byte(rmbp_pkg::CHAR_DOLLAR);
                end
                // one byte past the longest legal header line
                repeat (LINE_MAX)
                    send_byte(rmbp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
            end
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic config_limits(input logic [rmbp_pkg::COUNT_W-1:0] arg_max,
                                 input logic [rmbp_pkg::LEN_W-1:0] len_max);
        cfg_write <= 1'b1;
        cfg_index <= rmbp_pkg::CFG_MAX_ARG_COUNT;
        cfg_data  <= {{(rmbp_pkg::LEN_W-rmbp_pkg::COUNT_W){1'b0}}, arg_max};
        @(posedge clk);
        board.set_limit(rmbp_pkg::CFG_MAX_ARG_COUNT,
                        {{(rmbp_pkg::LEN_W-rmbp_pkg::COUNT_W){1'b0}}, arg_max});
        cfg_index <= rmbp_pkg::CFG_MAX_BULK_LENGTH;
        cfg_data  <= len_max;
        @(posedge clk);
        board.set_limit(rmbp_pkg::CFG_MAX_BULK_LENGTH, len_max);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int p;
        int phase_end;
        board      = new();
        in_mode    = 0;
        out_mode   = 0;
        items_sent = 0;
        cycles     = 0;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= rmbp_pkg::CFG_MAX_ARG_COUNT;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        data_byte  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two arguments: data extremes, then an empty argument; then a zero count
        send_line(rmbp_pkg::CHAR_STAR, "2");
        send_line(rmbp_pkg::CHAR_DOLLAR, "2");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_argument(0);
        send_line(rmbp_pkg::CHAR_STAR, "0");

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            if (p == 1)
                config_limits(21'd1, 30'd0);
            else if (p == 2)
                config_limits(rmbp_pkg::MAX_ARG_COUNT_RESET, rmbp_pkg::MAX_BULK_LENGTH_RESET);
            else if (p > 2)
                config_limits(rmbp_pkg::COUNT_W'($urandom_range(0, 1)
                                                 ? $urandom_range(1, 8)
                                                 : $urandom_range(1, 1048576)),
                              rmbp_pkg::LEN_W'($urandom_range(0, 1)
                                               ? $urandom_range(0, 64)
                                               : $urandom_range(0, 536870912)));
            in_mode  = (p == 0) ? 0 : $urandom_range(0, 2);
            out_mode = (p == 0) ? 0 : $urandom_range(0, 2);
            phase_end = items_sent + 250;
            while (items_sent < phase_end)
                send_random_request();
        end

        wait_idle();
        config_limits(rmbp_pkg::COUNT_W'($urandom_range(2, 50)),
                      rmbp_pkg::LEN_W'($urandom_range(0, 50)));
        in_mode  = 1;
        out_mode = 1;
        send_broken_request();
        // parser is silent from here on
        repeat ($urandom_range(5, 20))
            send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        repeat (8) @(posedge clk);
        board.check_drained();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
